// ===== src/invert_affine_3x4_macros.svh =====
// Assertion macros used by the checker file.
`ifndef INVERT_AFFINE_3X4_MACROS_SVH
`define INVERT_AFFINE_3X4_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define IA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define IA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/ia_pkg.sv =====
// Package with the word types and arithmetic helpers of the affine inverse.
package ia_pkg;
    typedef struct packed {
        logic signed [31:0] in_a00;
        logic signed [31:0] in_a01;
        logic signed [31:0] in_a02;
        logic signed [31:0] in_a10;
        logic signed [31:0] in_a11;
        logic signed [31:0] in_a12;
        logic signed [31:0] in_a20;
        logic signed [31:0] in_a21;
        logic signed [31:0] in_a22;
        logic signed [31:0] in_t0;
        logic signed [31:0] in_t1;
        logic signed [31:0] in_t2;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] inv_a00;
        logic signed [31:0] inv_a01;
        logic signed [31:0] inv_a02;
        logic signed [31:0] inv_a10;
        logic signed [31:0] inv_a11;
        logic signed [31:0] inv_a12;
        logic signed [31:0] inv_a20;
        logic signed [31:0] inv_a21;
        logic signed [31:0] inv_a22;
        logic signed [31:0] inv_t0;
        logic signed [31:0] inv_t1;
        logic signed [31:0] inv_t2;
    } t_out_word;

    // Clamp a 72-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [71:0] hi;
        logic signed [71:0] lo;
        begin
            hi = 72'sh7FFFFFFF;
            lo = -72'sh80000000;
            if (v > hi) sat32 = 32'sh7FFFFFFF;
            else if (v < lo) sat32 = 32'sh80000000;
            else sat32 = v[31:0];
        end
    endfunction
endpackage

// ===== src/ia_front.sv =====
// Front end: registers accepted words and forms the nine 2x2 minors.
module ia_front import ia_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_in_word    i_word,
    output logic        o_vld,
    output t_in_word    o_word,
    output logic signed [31:0] o_min [9]
);
    logic signed [63:0] r_pa [9];
    logic signed [63:0] r_pb [9];
    t_in_word r_w1;
    logic r_v1;
    logic signed [31:0] r_min [9];
    t_in_word r_w2;
    logic r_v2;
    logic signed [31:0] p [9];
    logic signed [31:0] q [9];
    logic signed [31:0] r [9];
    logic signed [31:0] s [9];

    // Operand selection for each minor, in cofactor order.
    always_comb begin
        p[0] = i_word.in_a11; q[0] = i_word.in_a22; r[0] = i_word.in_a21; s[0] = i_word.in_a12;
        p[1] = i_word.in_a10; q[1] = i_word.in_a22; r[1] = i_word.in_a20; s[1] = i_word.in_a12;
        p[2] = i_word.in_a10; q[2] = i_word.in_a21; r[2] = i_word.in_a20; s[2] = i_word.in_a11;
        p[3] = i_word.in_a01; q[3] = i_word.in_a22; r[3] = i_word.in_a21; s[3] = i_word.in_a02;
        p[4] = i_word.in_a00; q[4] = i_word.in_a22; r[4] = i_word.in_a20; s[4] = i_word.in_a02;
        p[5] = i_word.in_a00; q[5] = i_word.in_a21; r[5] = i_word.in_a20; s[5] = i_word.in_a01;
        p[6] = i_word.in_a01; q[6] = i_word.in_a12; r[6] = i_word.in_a11; s[6] = i_word.in_a02;
        p[7] = i_word.in_a00; q[7] = i_word.in_a12; r[7] = i_word.in_a10; s[7] = i_word.in_a02;
        p[8] = i_word.in_a00; q[8] = i_word.in_a11; r[8] = i_word.in_a10; s[8] = i_word.in_a01;
    end

    // Stage one: products; stage two: difference, floor shift and clamp.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_pa[k] <= 64'(p[k]) * 64'(q[k]);
            r_pb[k] <= 64'(r[k]) * 64'(s[k]);
            r_min[k] <= sat32((72'(r_pa[k]) - 72'(r_pb[k])) >>> FRAC_BITS);
        end
        r_w1 <= i_word;
        r_w2 <= r_w1;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    assign o_vld = r_v2;
    assign o_word = r_w2;
    assign o_min = r_min;
endmodule

// ===== src/ia_queue.sv =====
// Short queue between the front end and the back end.
module ia_queue import ia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_in_word    i_word,
    input  logic signed [31:0] i_min [9],
    output logic        o_vld,
    output t_in_word    o_word,
    output logic signed [31:0] o_min [9]
);
    // Back end never stalls, so the queue is a single register stage.
    t_in_word r_word;
    logic signed [31:0] r_min [9];
    logic r_vld;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_word <= i_word;
            r_min <= i_min;
        end
        if (!i_rst_n) r_vld <= 1'b0;
        else r_vld <= i_push;
    end

    assign o_vld = r_vld;
    assign o_word = r_word;
    assign o_min = r_min;
endmodule

// ===== src/ia_div.sv =====
// Pipelined restoring divider: 2^(2F) by |det|, one quotient bit per stage.
module ia_div import ia_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic signed [31:0] i_det,
    output logic signed [31:0] o_rec
);
    localparam int unsigned NUM_W = 2 * FRAC_BITS + 1;
    localparam logic [NUM_W-1:0] NUM = NUM_W'(1) << (2 * FRAC_BITS);

    logic [32:0] r_rem [NUM_W+1];
    logic [NUM_W-1:0] r_quo [NUM_W+1];
    logic [32:0] r_den [NUM_W+1];
    logic r_neg [NUM_W+1];
    logic r_zero [NUM_W+1];
    logic [33:0] trial [NUM_W];

    always_comb begin
        for (int k = 0; k < NUM_W; k++) begin
            trial[k] = {r_rem[k], NUM[NUM_W-1-k]} - {1'b0, r_den[k]};
        end
    end

    // Each stage shifts one numerator bit in and subtracts when it fits.
    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_quo[0] <= '0;
        r_den[0] <= i_det[31] ? 33'(-{i_det[31], i_det}) : {1'b0, i_det};
        r_neg[0] <= i_det[31];
        r_zero[0] <= (i_det == '0);
        for (int k = 0; k < NUM_W; k++) begin
            if (!trial[k][33]) begin
                r_rem[k+1] <= trial[k][32:0];
                r_quo[k+1] <= {r_quo[k][NUM_W-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= {r_rem[k][31:0], NUM[NUM_W-1-k]};
                r_quo[k+1] <= {r_quo[k][NUM_W-2:0], 1'b0};
            end
            r_den[k+1] <= r_den[k];
            r_neg[k+1] <= r_neg[k];
            r_zero[k+1] <= r_zero[k];
        end
    end

    // Sign, clamp and zero-determinant handling.
    always_comb begin
        logic signed [71:0] q;
        q = 72'(r_quo[NUM_W]);
        if (r_neg[NUM_W]) q = -q;
        if (r_zero[NUM_W]) o_rec = 32'sh7FFFFFFF;
        else o_rec = sat32(q);
    end
endmodule

// ===== src/ia_back.sv =====
// Back end: determinant, reciprocal, inverse matrix and translation.
module ia_back import ia_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  t_in_word    i_word,
    input  logic signed [31:0] i_min [9],
    output logic        o_vld,
    output t_out_word   o_word
);
    localparam int unsigned DLAT = 2 * FRAC_BITS + 2;
    localparam int unsigned LAT = DLAT + 6;

    logic r_v [LAT];
    t_in_word r_w [DLAT+2];
    logic signed [31:0] r_m [DLAT+2][9];
    logic signed [63:0] r_dp [3];
    logic signed [31:0] r_det;
    logic signed [31:0] rec;
    logic signed [63:0] r_bp [9];
    logic signed [31:0] r_b [9];
    logic signed [31:0] r_b2 [9];
    t_in_word r_tw;
    t_in_word r_tw2;
    logic signed [63:0] r_up [9];
    logic signed [31:0] r_b3 [9];
    logic signed [31:0] r_u [3];
    logic signed [31:0] sgn_m [9];

    // Valid shift line for the whole back end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_v[k] <= 1'b0;
        end else begin
            r_v[0] <= i_vld;
            for (int k = 1; k < LAT; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Determinant products, then sum, floor and clamp.
    always_ff @(posedge i_clk) begin
        r_dp[0] <= 64'(i_word.in_a00) * 64'(i_min[0]);
        r_dp[1] <= 64'(i_word.in_a01) * 64'(i_min[1]);
        r_dp[2] <= 64'(i_word.in_a02) * 64'(i_min[2]);
        r_det <= sat32((72'(r_dp[0]) - 72'(r_dp[1]) + 72'(r_dp[2])) >>> FRAC_BITS);
        r_w[0] <= i_word;
        r_m[0] <= i_min;
        for (int k = 1; k < DLAT + 2; k++) begin
            r_w[k] <= r_w[k-1];
            r_m[k] <= r_m[k-1];
        end
    end

    ia_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk (i_clk),
        .i_det (r_det),
        .o_rec (rec)
    );

    // Minors delayed to line up with the reciprocal.
    always_comb begin
        for (int k = 0; k < 9; k++) sgn_m[k] = r_m[DLAT+1][k];
    end

    // Inverse matrix products in adjugate order, then floor and clamp.
    always_ff @(posedge i_clk) begin
        r_bp[0] <= 64'(rec) * 64'(sgn_m[0]);
        r_bp[1] <= -(64'(rec) * 64'(sgn_m[3]));
        r_bp[2] <= 64'(rec) * 64'(sgn_m[6]);
        r_bp[3] <= -(64'(rec) * 64'(sgn_m[1]));
        r_bp[4] <= 64'(rec) * 64'(sgn_m[4]);
        r_bp[5] <= -(64'(rec) * 64'(sgn_m[7]));
        r_bp[6] <= 64'(rec) * 64'(sgn_m[2]);
        r_bp[7] <= -(64'(rec) * 64'(sgn_m[5]));
        r_bp[8] <= 64'(rec) * 64'(sgn_m[8]);
        r_tw <= r_w[DLAT+1];
        for (int k = 0; k < 9; k++) r_b[k] <= sat32(72'(r_bp[k]) >>> FRAC_BITS);
        r_tw2 <= r_tw;
    end

    // Translation products, then negated three-term sums.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_up[3*i]   <= 64'(r_tw2.in_t0) * 64'(r_b[3*i]);
            r_up[3*i+1] <= 64'(r_tw2.in_t1) * 64'(r_b[3*i+1]);
            r_up[3*i+2] <= 64'(r_tw2.in_t2) * 64'(r_b[3*i+2]);
        end
        r_b2 <= r_b;
        for (int i = 0; i < 3; i++) begin
            r_u[i] <= sat32((-72'(r_up[3*i]) - 72'(r_up[3*i+1]) - 72'(r_up[3*i+2]))
                            >>> FRAC_BITS);
        end
        r_b3 <= r_b2;
    end

    assign o_vld = r_v[DLAT+5];
    always_comb begin
        o_word.inv_a00 = r_b3[0]; o_word.inv_a01 = r_b3[1]; o_word.inv_a02 = r_b3[2];
        o_word.inv_a10 = r_b3[3]; o_word.inv_a11 = r_b3[4]; o_word.inv_a12 = r_b3[5];
        o_word.inv_a20 = r_b3[6]; o_word.inv_a21 = r_b3[7]; o_word.inv_a22 = r_b3[8];
        o_word.inv_t0 = r_u[0]; o_word.inv_t1 = r_u[1]; o_word.inv_t2 = r_u[2];
    end
endmodule

// ===== src/invert_affine_3x4.sv =====
// Top level of the pipelined 3x4 affine transform inverter.
//  channel   | signals                      | handshake
//  command   | start, busy, i_word          | accepted when start high, busy low
//  result    | o_done, o_word               | one-cycle strobe, no back pressure
// One word is taken every cycle; busy is tied low, also in reset.
// o_done rises for a command word once it has passed the front end, queue and back end.
// Most of that delay comes from the one-bit-per-stage reciprocal divider.
// Reset is synchronous and clears only the valid bits of the pipeline.
// The receiver cannot stall, so the pipeline never stops.
module invert_affine_3x4 import ia_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output logic      o_done,
    output t_out_word o_word
);
    logic f_vld;
    t_in_word f_word;
    logic signed [31:0] f_min [9];
    logic q_vld;
    t_in_word q_word;
    logic signed [31:0] q_min [9];

    assign busy = 1'b0;

    ia_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (start && !busy),
        .i_word (i_word), .o_vld (f_vld), .o_word (f_word), .o_min (f_min)
    );

    ia_queue u_queue (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_push (f_vld), .i_word (f_word),
        .i_min (f_min), .o_vld (q_vld), .o_word (q_word), .o_min (q_min)
    );

    ia_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_vld (q_vld), .i_word (q_word),
        .i_min (q_min), .o_vld (o_done), .o_word (o_word)
    );
endmodule

// ===== src/ia_checker.sv =====
// Port-level checker for the affine inverter and its bind.
`include "invert_affine_3x4_macros.svh"
module ia_checker import ia_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done
);
    // The block never refuses a command word.
    `IA_ASSERT_IMPL(a_no_busy, i_clk, i_rst_n, 1'b1, !busy)
    // Nothing comes out in the cycle right after reset is released.
    `IA_ASSERT_NEXT(a_rst_quiet, i_clk, 1'b1, !i_rst_n, !o_done)
    // The done strobe is never unknown outside reset.
    `IA_ASSERT_IMPL(a_done_known, i_clk, i_rst_n, 1'b1, !$isunknown(o_done))
endmodule

bind invert_affine_3x4 ia_checker u_ia_checker (
    .i_clk (i_clk), .i_rst_n (i_rst_n), .start (start), .busy (busy), .o_done (o_done)
);
